// File: design/chp_pkg.sv
// Shared widths, constants, register indexes and types of the cubic Hermite point evaluator.
`default_nettype none

package chp_pkg;

    // Curve parameter and its powers (unsigned).
    localparam int T_W    = 17;
    localparam int T_SQ_W = 33;
    localparam int T_CU_W = 49;

    // Basis polynomials in Q.48, signed, with headroom for the intermediate sums.
    localparam int H_W  = 52;
    // Tangent basis values after trimming (magnitude stays below 2^46).
    localparam int HN_W = 47;

    // Tangent gain, signed Q4.12.
    localparam int GAIN_W = 16;

    // Gain times tangent basis, Q.60.
    localparam int P_W = 63;

    // Basis weights in Q.30, signed.
    localparam int W_W    = 34;
    localparam int W_FRAC = 30;

    localparam logic [T_W-1:0]    T_ONE      = 17'h1_0000;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

    // Register indexes of the configuration port.
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_START_POINT   = 3'd0;
    localparam logic [IDX_W-1:0] REG_END_TANGENT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_START_TANGENT = 3'd2;
    localparam logic [IDX_W-1:0] REG_END_POINT     = 3'd3;
    localparam logic [IDX_W-1:0] REG_TANGENT_GAIN  = 3'd4;

    // The four basis weights of one curve parameter, all Q.30.
    typedef struct packed {
        logic signed [W_W-1:0] w00;
        logic signed [W_W-1:0] w01;
        logic signed [W_W-1:0] g10;
        logic signed [W_W-1:0] g11;
    } t_weights;

endpackage

`default_nettype wire

// File: design/chp_in_if.sv
// Input channel of the evaluator: one curve parameter per word.
`default_nettype none

interface chp_in_if;
    import chp_pkg::*;

    logic           valid;
    logic           ready;
    logic [T_W-1:0] t_param;

    modport source (output valid, output t_param, input ready);
    modport sink   (input valid, input t_param, output ready);

endinterface

`default_nettype wire

// File: design/chp_out_if.sv
// Output channel of the evaluator: one curve point per word.
`default_nettype none

interface chp_out_if #(
    parameter int COORD_WIDTH = 16
);

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_out;
    logic signed [COORD_WIDTH-1:0] y_out;

    modport source (output valid, output x_out, output y_out, input ready);
    modport sink   (input valid, input x_out, input y_out, output ready);

endinterface

`default_nettype wire

// File: design/cubic_hermite_2d_point_eval.sv
// Top level of the two-dimensional cubic Hermite curve point evaluator.
//
//   Channel   Direction  Word contents
//   i_pt      in         t_param: curve parameter, unsigned Q1.16, 65536 is 1.0
//   o_pt      out        x_out, y_out: curve point, signed Q8.8, saturated
//   i_cfg_*   in         register index and write data (no handshake)
//
// One word is accepted per cycle while the pipeline is not halted. After its
// parameter is accepted, five stages compute the basis weights, two form the
// weighted sums per axis, and the output register holds the rounded point.
// Reset clears all valid bits and sets the gain to one, the points to zero.
// A stalled output keeps its word while a skid register catches the next one;
// the pipeline halts only while that skid register is full.
//
// The points and the gain are read straight from the configuration registers,
// so they should be written only while no word is in flight.
`default_nettype none

module cubic_hermite_2d_point_eval #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    chp_in_if.sink                                 i_pt,
    chp_out_if.source                              o_pt,
    input  wire logic                              i_cfg_we,
    input  wire logic [chp_pkg::IDX_W-1:0]         i_cfg_index,
    input  wire logic [2*COORD_WIDTH-1:0]          i_cfg_data
);
    import chp_pkg::*;

    localparam int CW = COORD_WIDTH;

    // Configuration registers.
    logic [2*CW-1:0]          r_start_point;
    logic [2*CW-1:0]          r_end_tangent;
    logic [2*CW-1:0]          r_start_tangent;
    logic [2*CW-1:0]          r_end_point;
    logic signed [GAIN_W-1:0] r_tangent_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_point   <= '0;
            r_end_tangent   <= '0;
            r_start_tangent <= '0;
            r_end_point     <= '0;
            r_tangent_gain  <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_POINT:   r_start_point   <= i_cfg_data;
                REG_END_TANGENT:   r_end_tangent   <= i_cfg_data;
                REG_START_TANGENT: r_start_tangent <= i_cfg_data;
                REG_END_POINT:     r_end_point     <= i_cfg_data;
                REG_TANGENT_GAIN:  r_tangent_gain  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves together; it halts only when the skid
    // register already holds a word, which is a registered condition.
    logic     en;
    logic     r_skid_valid;
    logic     b_valid;
    t_weights b_weights;
    logic     r_v6, r_v7;

    assign en         = !r_skid_valid;
    assign i_pt.ready = en;

    chp_basis u_basis (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_pt.valid),
        .i_t       (i_pt.t_param),
        .i_gain    (r_tangent_gain),
        .o_valid   (b_valid),
        .o_weights (b_weights)
    );

    logic signed [CW-1:0] x_res, y_res;

    chp_axis #(.CW(CW)) u_axis_x (
        .i_clk           (i_clk),
        .i_en            (en),
        .i_weights       (b_weights),
        .i_start_point   ($signed(r_start_point[CW-1:0])),
        .i_end_point     ($signed(r_end_point[CW-1:0])),
        .i_start_tangent ($signed(r_start_tangent[CW-1:0])),
        .i_end_tangent   ($signed(r_end_tangent[CW-1:0])),
        .o_coord         (x_res)
    );

    chp_axis #(.CW(CW)) u_axis_y (
        .i_clk           (i_clk),
        .i_en            (en),
        .i_weights       (b_weights),
        .i_start_point   ($signed(r_start_point[2*CW-1:CW])),
        .i_end_point     ($signed(r_end_point[2*CW-1:CW])),
        .i_start_tangent ($signed(r_start_tangent[2*CW-1:CW])),
        .i_end_tangent   ($signed(r_end_tangent[2*CW-1:CW])),
        .o_coord         (y_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (en) begin
            r_v6 <= b_valid;
            r_v7 <= r_v6;
        end
    end

    // Output register plus skid register.
    logic                 push, pop;
    logic                 r_out_valid;
    logic signed [CW-1:0] r_out_x, r_out_y;
    logic signed [CW-1:0] r_skid_x, r_skid_y;

    assign push = en && r_v7;
    assign pop  = r_out_valid && o_pt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_x      <= r_skid_x;
                r_out_y      <= r_skid_y;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !pop) begin
                r_skid_x     <= x_res;
                r_skid_y     <= y_res;
                r_skid_valid <= 1'b1;
            end else begin
                r_out_x     <= x_res;
                r_out_y     <= y_res;
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_pt.valid = r_out_valid;
    assign o_pt.x_out = r_out_x;
    assign o_pt.y_out = r_out_y;

endmodule

`default_nettype wire

// File: design/chp_basis.sv
// Five-stage pipeline that turns a curve parameter into the four Hermite basis weights.
`default_nettype none

module chp_basis (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [chp_pkg::T_W-1:0]      i_t,
    input  wire logic signed [chp_pkg::GAIN_W-1:0] i_gain,
    output logic                              o_valid,
    output chp_pkg::t_weights                 o_weights
);
    import chp_pkg::*;

    localparam logic signed [H_W-1:0] ONE_Q48 = H_W'(1) << 48;
    localparam int                    SH_H    = 48 - W_FRAC;
    localparam logic signed [H_W-1:0] RND_H   = H_W'(1) << (SH_H - 1);
    localparam int                    SH_P    = 60 - W_FRAC;
    localparam logic signed [P_W-1:0] RND_P   = P_W'(1) << (SH_P - 1);

    logic [4:0] r_vld;

    // Stage 1: clamp and square.
    logic [T_W-1:0]      n_t;
    logic [2*T_W-1:0]    n_t2_full;
    logic [T_W-1:0]      r1_t;
    logic [T_SQ_W-1:0]   r1_t2;

    // Stage 2: cube.
    logic [T_SQ_W+T_W-1:0] n_t3_full;
    logic [T_W-1:0]        r2_t;
    logic [T_SQ_W-1:0]     r2_t2;
    logic [T_CU_W-1:0]     r2_t3;

    // Stage 3: basis polynomials and rounding of the point weights.
    logic signed [H_W-1:0]  u3, u2, u1;
    logic signed [H_W-1:0]  h00, h01, h10, h11;
    logic signed [H_W-1:0]  rh00, rh01;
    logic signed [W_W-1:0]  r3_w00, r3_w01;
    logic signed [HN_W-1:0] r3_h10, r3_h11;

    // Stage 4: gain products.
    logic signed [P_W-1:0]  n_p10, n_p11;
    logic signed [W_W-1:0]  r4_w00, r4_w01;
    logic signed [P_W-1:0]  r4_p10, r4_p11;

    // Stage 5: rounding of the tangent weights.
    logic signed [P_W-1:0]  rp10, rp11;
    logic signed [W_W-1:0]  r5_w00, r5_w01, r5_g10, r5_g11;

    always_comb begin
        n_t       = (i_t > T_ONE) ? T_ONE : i_t;
        n_t2_full = {{T_W{1'b0}}, n_t} * {{T_W{1'b0}}, n_t};
        n_t3_full = {{T_W{1'b0}}, r1_t2} * {{T_SQ_W{1'b0}}, r1_t};

        u3 = {{(H_W-T_CU_W){1'b0}}, r2_t3};
        u2 = {{(H_W-T_SQ_W-16){1'b0}}, r2_t2, 16'b0};
        u1 = {{(H_W-T_W-32){1'b0}}, r2_t, 32'b0};

        h00 = (u3 <<< 1) - u2 - (u2 <<< 1) + ONE_Q48;
        h01 = u2 + (u2 <<< 1) - (u3 <<< 1);
        h10 = u3 - (u2 <<< 1) + u1;
        h11 = u3 - u2;

        rh00 = (h00 + RND_H) >>> SH_H;
        rh01 = (h01 + RND_H) >>> SH_H;

        n_p10 = P_W'(r3_h10) * P_W'(i_gain);
        n_p11 = P_W'(r3_h11) * P_W'(i_gain);

        rp10 = (r4_p10 + RND_P) >>> SH_P;
        rp11 = (r4_p11 + RND_P) >>> SH_P;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t   <= n_t;
            r1_t2  <= n_t2_full[T_SQ_W-1:0];

            r2_t   <= r1_t;
            r2_t2  <= r1_t2;
            r2_t3  <= n_t3_full[T_CU_W-1:0];

            r3_w00 <= rh00[W_W-1:0];
            r3_w01 <= rh01[W_W-1:0];
            r3_h10 <= h10[HN_W-1:0];
            r3_h11 <= h11[HN_W-1:0];

            r4_w00 <= r3_w00;
            r4_w01 <= r3_w01;
            r4_p10 <= n_p10;
            r4_p11 <= n_p11;

            r5_w00 <= r4_w00;
            r5_w01 <= r4_w01;
            r5_g10 <= rp10[W_W-1:0];
            r5_g11 <= rp11[W_W-1:0];
        end
    end

    assign o_valid       = r_vld[4];
    assign o_weights.w00 = r5_w00;
    assign o_weights.w01 = r5_w01;
    assign o_weights.g10 = r5_g10;
    assign o_weights.g11 = r5_g11;

endmodule

`default_nettype wire

// File: design/chp_axis.sv
// One coordinate axis: weighted products, their sum, rounding and saturation.
`default_nettype none

module chp_axis #(
    parameter int CW = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire chp_pkg::t_weights       i_weights,
    input  wire logic signed [CW-1:0]    i_start_point,
    input  wire logic signed [CW-1:0]    i_end_point,
    input  wire logic signed [CW-1:0]    i_start_tangent,
    input  wire logic signed [CW-1:0]    i_end_tangent,
    output logic signed [CW-1:0]         o_coord
);
    import chp_pkg::*;

    localparam int M_W = W_W + CW;
    localparam int S_W = M_W + 2;
    localparam int R_W = S_W - W_FRAC;
    localparam logic signed [S_W-1:0] RND = S_W'(1) << (W_FRAC - 1);
    localparam logic signed [R_W-1:0] HI  = {{(R_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [R_W-1:0] LO  = {{(R_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

    logic signed [M_W-1:0] n_m00, n_m01, n_m10, n_m11;
    logic signed [M_W-1:0] r_m00, r_m01, r_m10, r_m11;
    logic signed [S_W-1:0] n_sum, r_sum;
    logic signed [S_W-1:0] rounded;
    logic signed [R_W-1:0] res;

    always_comb begin
        n_m00 = M_W'(i_weights.w00) * M_W'(i_start_point);
        n_m01 = M_W'(i_weights.w01) * M_W'(i_end_point);
        n_m10 = M_W'(i_weights.g10) * M_W'(i_start_tangent);
        n_m11 = M_W'(i_weights.g11) * M_W'(i_end_tangent);

        n_sum = S_W'(r_m00) + S_W'(r_m01) + S_W'(r_m10) + S_W'(r_m11);

        rounded = (r_sum + RND) >>> W_FRAC;
        res     = rounded[R_W-1:0];
        if (res > HI) begin
            o_coord = HI[CW-1:0];
        end else if (res < LO) begin
            o_coord = LO[CW-1:0];
        end else begin
            o_coord = res[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m00 <= n_m00;
            r_m01 <= n_m01;
            r_m10 <= n_m10;
            r_m11 <= n_m11;
            r_sum <= n_sum;
        end
    end

endmodule

`default_nettype wire
